// ===== sv/lge_pkg.sv =====
// lge_pkg: shared types and constants for the life grid generation engine
// no dependencies; imported by every module of the block
package lge_pkg;

    localparam int DEF_GRID_COLS = 64;
    localparam int DEF_GRID_ROWS = 64;

    // opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_STEP   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // neighbor counts of the b3/s23 rule
    localparam logic [3:0] NBR_BIRTH = 4'd3;
    localparam logic [3:0] NBR_KEEP  = 4'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] cell_col;
        logic [5:0] cell_row;
        logic       new_live;
    } t_cmd;

    typedef struct packed {
        logic cell_live;
        logic coord_error;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_STEP,
        ST_RESP
    } t_state;

endpackage

// ===== sv/lge_col_mem.sv =====
// lge_col_mem: column store, one word per grid column, registered read
// per-column valid bits cleared at reset make unwritten columns read as dead
// depends on lge_pkg
module lge_col_mem import lge_pkg::*; #(
    parameter int DEPTH = DEF_GRID_COLS,
    parameter int WIDTH = DEF_GRID_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== sv/lge_col_rule.sv =====
// lge_col_rule: new generation of one column from the old column and its two neighbors
// one lane per row, cells beyond the grid edge count as dead; depends on lge_pkg
module lge_col_rule import lge_pkg::*; #(
    parameter int ROWS = DEF_GRID_ROWS
) (
    input  logic [ROWS-1:0] i_left,
    input  logic [ROWS-1:0] i_mid,
    input  logic [ROWS-1:0] i_right,
    output logic [ROWS-1:0] o_next
);

    logic [ROWS+1:0] left_ext;
    logic [ROWS+1:0] mid_ext;
    logic [ROWS+1:0] right_ext;

    assign left_ext  = {1'b0, i_left, 1'b0};
    assign mid_ext   = {1'b0, i_mid, 1'b0};
    assign right_ext = {1'b0, i_right, 1'b0};

    for (genvar r = 0; r < ROWS; r++) begin : g_lane
        logic [3:0] count;
        assign count = 4'(left_ext[r]) + 4'(left_ext[r+1]) + 4'(left_ext[r+2])
                     + 4'(mid_ext[r]) + 4'(mid_ext[r+2])
                     + 4'(right_ext[r]) + 4'(right_ext[r+1]) + 4'(right_ext[r+2]);
        assign o_next[r] = (count == NBR_BIRTH) || (i_mid[r] && (count == NBR_KEEP));
    end

endmodule

// ===== sv/life_grid_generation_engine_top.sv =====
// life_grid_generation_engine_top: bounded b3/s23 life grid with cell read, write and step
// depends on lge_pkg, lge_col_mem, lge_col_rule
//
// channel   direction  handshake                 payload
// command   in         start, busy               i_cmd    (t_cmd)
// result    out        o_done (one-cycle strobe) o_result (t_result)
//
// read and write: ST_CELL, then ST_RESP shows the result; ready again when the block returns to ST_IDLE
// coordinates outside the grid or unused opcode: result in the cycle after the transaction, in ST_RESP
// step: ST_STEP sweeps the columns, then ST_RESP shows the result; the column store has one
// read and one write port, so the sweep reads one column per cycle, writing behind the read
// busy stays high from the transaction until the cycle after o_done
// synchronous active-low reset; the grid reads as all dead right after reset

module life_grid_generation_engine_top import lge_pkg::*; #(
    parameter int GRID_COLS = DEF_GRID_COLS,
    parameter int GRID_ROWS = DEF_GRID_ROWS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    localparam int CW = $clog2(GRID_COLS);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int IW = $clog2(GRID_COLS + 2);
    localparam logic [IW-1:0] IDX_COLS = IW'(GRID_COLS);
    localparam logic [IW-1:0] IDX_LAST = IW'(GRID_COLS + 1);
    localparam logic [IW-1:0] IDX_TWO  = IW'(2);
    localparam logic [8:0]    LIM_COLS = 9'(GRID_COLS);
    localparam logic [8:0]    LIM_ROWS = 9'(GRID_ROWS);

    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [GRID_ROWS-1:0] r_left, n_left;
    logic [GRID_ROWS-1:0] r_mid, n_mid;
    t_cmd              r_cmd, n_cmd;
    t_result           r_resp, n_resp;

    logic [CW-1:0]        mem_rd_addr;
    logic [GRID_ROWS-1:0] mem_rd_data;
    logic                 mem_wr_en;
    logic [CW-1:0]        mem_wr_addr;
    logic [GRID_ROWS-1:0] mem_wr_data;
    logic [GRID_ROWS-1:0] right_col;
    logic [GRID_ROWS-1:0] rule_col;
    logic [GRID_ROWS-1:0] cell_word;
    logic                 in_grid;

    lge_col_mem #(
        .DEPTH (GRID_COLS),
        .WIDTH (GRID_ROWS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    lge_col_rule #(
        .ROWS (GRID_ROWS)
    ) u_rule (
        .i_left  (r_left),
        .i_mid   (r_mid),
        .i_right (right_col),
        .o_next  (rule_col)
    );

    assign in_grid = ({3'b0, i_cmd.cell_col} < LIM_COLS) && ({3'b0, i_cmd.cell_row} < LIM_ROWS);

    // column after the last one reads as dead
    assign right_col = (r_idx <= IDX_COLS) ? mem_rd_data : '0;

    always_comb begin
        cell_word = mem_rd_data;
        cell_word[RW'(r_cmd.cell_row)] = r_cmd.new_live;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_mid  <= n_mid;
        r_cmd  <= n_cmd;
        r_resp <= n_resp;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_left      = r_left;
        n_mid       = r_mid;
        n_cmd       = r_cmd;
        n_resp      = r_resp;
        mem_rd_addr = CW'(i_cmd.cell_col);
        mem_wr_en   = 1'b0;
        mem_wr_addr = CW'(r_cmd.cell_col);
        mem_wr_data = cell_word;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd  = i_cmd;
                    n_resp = '0;
                    unique case (i_cmd.opcode)
                        OP_WRITE, OP_READ: begin
                            if (in_grid) begin
                                n_state = ST_CELL;
                            end else begin
                                n_resp.coord_error = 1'b1;
                                n_state = ST_RESP;
                            end
                        end
                        OP_STEP: begin
                            n_idx   = '0;
                            n_left  = '0;
                            n_mid   = '0;
                            n_state = ST_STEP;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_CELL: begin
                if (r_cmd.opcode == OP_WRITE) begin
                    mem_wr_en = 1'b1;
                end else begin
                    n_resp.cell_live = mem_rd_data[RW'(r_cmd.cell_row)];
                end
                n_state = ST_RESP;
            end
            ST_STEP: begin
                mem_rd_addr = (r_idx < IDX_COLS) ? CW'(r_idx) : '0;
                if (r_idx != '0) begin
                    n_left = r_mid;
                    n_mid  = right_col;
                end
                if (r_idx >= IDX_TWO) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = CW'(r_idx - IDX_TWO);
                    mem_wr_data = rule_col;
                end
                if (r_idx == IDX_LAST) begin
                    n_state = ST_RESP;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = (r_state == ST_RESP);
    assign o_result = r_resp;

endmodule

// ===== sv/lge_checker.sv =====
// lge_checker: port-level checks on the command and result channels
// depends on lge_pkg; bound to life_grid_generation_engine_top
module lge_checker import lge_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_cmd    i_cmd,
    input logic    o_done,
    input t_result o_result
);

    // a transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after transaction");

    // a result is only shown while the block is busy
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // one result per transaction, then ready again
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe longer than one cycle or block stays busy");

    // an out-of-grid result never carries a cell value
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.coord_error && o_result.cell_live))
        else $error("coordinate error with live cell");

    // a step never reports a coordinate error
    a_step_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.opcode == OP_STEP)) |=> !o_result.coord_error)
        else $error("step result has coordinate error");

endmodule

bind life_grid_generation_engine_top lge_checker u_lge_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== sim/lge_checker.sv =====
// lge_tb_checker: predicts the life grid engine's results and compares them on the result channel
// depends on lge_pkg; instantiated by the testbench top beside the block
`timescale 1ns / 1ps

module lge_tb_checker import lge_pkg::*; #(
    parameter int GRID_COLS = DEF_GRID_COLS,
    parameter int GRID_ROWS = DEF_GRID_ROWS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_cmd    i_cmd,
    input  logic    i_done,
    input  t_result i_result,
    output int      o_errors,
    output int      o_pending
);

    logic [GRID_ROWS-1:0] live_cells [GRID_COLS];
    t_result              expected_results [$];
    int                   error_count = 0;

    assign o_errors  = error_count;
    assign o_pending = expected_results.size();

    initial begin
        for (int c = 0; c < GRID_COLS; c++) begin
            live_cells[c] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("%0t: mismatch on %s: got %b, expected %b", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int live_neighbors(input int col, input int row);
        int count;
        count = 0;
        for (int dc = -1; dc <= 1; dc++) begin
            for (int dr = -1; dr <= 1; dr++) begin
                if ((dc != 0 || dr != 0) && col + dc >= 0 && col + dc < GRID_COLS &&
                    row + dr >= 0 && row + dr < GRID_ROWS) begin
                    count += live_cells[col + dc][row + dr];
                end
            end
        end
        return count;
    endfunction

    task automatic advance_generation();
        logic [GRID_ROWS-1:0] next_cells [GRID_COLS];
        int                   n;
        for (int c = 0; c < GRID_COLS; c++) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
                n = live_neighbors(c, r);
                if (live_cells[c][r]) begin
                    next_cells[c][r] = (n == NBR_KEEP || n == NBR_BIRTH);
                end else begin
                    next_cells[c][r] = (n == NBR_BIRTH);
                end
            end
        end
        for (int c = 0; c < GRID_COLS; c++) begin
            live_cells[c] = next_cells[c];
        end
    endtask

    task automatic apply_cmd(input t_cmd c, output t_result r);
        logic on_grid;
        on_grid = (c.cell_col < GRID_COLS) && (c.cell_row < GRID_ROWS);
        r = '0;
        if (c.opcode == OP_WRITE || c.opcode == OP_READ) begin
            if (!on_grid) begin
                r.coord_error = 1'b1;
            end else if (c.opcode == OP_WRITE) begin
                live_cells[c.cell_col][c.cell_row] = c.new_live;
            end else begin
                r.cell_live = live_cells[c.cell_col][c.cell_row];
            end
        end else if (c.opcode == OP_STEP) begin
            advance_generation();
        end
    endtask

    // command transaction
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && i_start && !i_busy) begin
            apply_cmd(i_cmd, r);
            expected_results = {expected_results, r};
        end
    end

    // result transaction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && i_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch("o_done", 1'b1, 1'b0);
            end else begin
                want = expected_results.pop_front();
                if (i_result.cell_live !== want.cell_live) begin
                    report_mismatch("cell_live", i_result.cell_live, want.cell_live);
                end
                if (i_result.coord_error !== want.coord_error) begin
                    report_mismatch("coord_error", i_result.coord_error, want.coord_error);
                end
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
// testbench: drives directed and random cell writes, reads, generation steps and unused opcodes
// depends on lge_pkg, life_grid_generation_engine_top and lge_tb_checker
`timescale 1ns / 1ps

module testbench;
    import lge_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 550;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_cmd    i_cmd   = '0;
    logic    o_done;
    t_result o_result;
    int      errors;
    int      pending;
    int      idle_cycles = 0;
    logic    no_idle     = 1'b0;
    int      random_sent = 0;

    always #1 i_clk = ~i_clk;

    life_grid_generation_engine_top #(
        .GRID_COLS(DEF_GRID_COLS),
        .GRID_ROWS(DEF_GRID_ROWS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_result(o_result)
    );

    lge_tb_checker #(
        .GRID_COLS(DEF_GRID_COLS),
        .GRID_ROWS(DEF_GRID_ROWS)
    ) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_cmd    (i_cmd),
        .i_done   (o_done),
        .i_result (o_result),
        .o_errors (errors),
        .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(input logic [1:0] op, input int col, input int row,
                                      input logic live);
        t_cmd c;
        c.opcode   = op;
        c.cell_col = col[5:0];
        c.cell_row = row[5:0];
        c.new_live = live;
        return c;
    endfunction

    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input t_cmd c);
        send_cmd(c);
        random_sent++;
    endtask

    initial begin
        int col0;
        int row0;
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: cleared grid, corner block, isolated corner cell, blinker on the edge, unused opcode
        send_cmd(make_cmd(OP_READ, 5, 5, 1'b1));
        send_cmd(make_cmd(OP_WRITE, 0, 0, 1'b1));
        send_cmd(make_cmd(OP_WRITE, 0, 1, 1'b1));
        send_cmd(make_cmd(OP_WRITE, 1, 0, 1'b1));
        send_cmd(make_cmd(OP_WRITE, 1, 1, 1'b1));
        send_cmd(make_cmd(OP_WRITE, 63, 63, 1'b1));
        send_cmd(make_cmd(OP_WRITE, 63, 30, 1'b1));
        send_cmd(make_cmd(OP_WRITE, 63, 31, 1'b1));
        send_cmd(make_cmd(OP_WRITE, 63, 32, 1'b1));
        send_cmd(make_cmd(OP_READ, 63, 63, 1'b0));
        send_cmd(make_cmd(OP_UNUSED, 63, 63, 1'b1));
        send_cmd(make_cmd(OP_STEP, 63, 63, 1'b1));
        send_cmd(make_cmd(OP_READ, 0, 0, 1'b0));
        send_cmd(make_cmd(OP_READ, 63, 63, 1'b0));
        send_cmd(make_cmd(OP_READ, 62, 31, 1'b0));
        send_cmd(make_cmd(OP_READ, 63, 31, 1'b0));
        send_cmd(make_cmd(OP_READ, 63, 30, 1'b0));
        send_cmd(make_cmd(OP_WRITE, 1, 1, 1'b0));
        send_cmd(make_cmd(OP_READ, 1, 1, 1'b0));
        send_cmd(make_cmd(OP_STEP, 0, 0, 1'b0));
        send_cmd(make_cmd(OP_READ, 1, 1, 1'b0));
        send_cmd(make_cmd(OP_READ, 0, 0, 1'b0));
        drain_results();

        // random: seed a small window, run a few generations, probe the window, then send random commands of any opcode
        while (random_sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 9) < 3);
            case ($urandom_range(0, 3))
                0: col0 = 0;
                1: col0 = 56;
                default: col0 = $urandom_range(0, 56);
            endcase
            case ($urandom_range(0, 3))
                0: row0 = 0;
                1: row0 = 56;
                default: row0 = $urandom_range(0, 56);
            endcase
            n = $urandom_range(10, 20);
            repeat (n) begin
                send_random(make_cmd(OP_WRITE, col0 + $urandom_range(0, 7),
                                     row0 + $urandom_range(0, 7),
                                     $urandom_range(0, 99) < 55));
            end
            n = $urandom_range(1, 4);
            repeat (n) begin
                send_random(make_cmd(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                                     1'($urandom_range(0, 1))));
            end
            n = $urandom_range(6, 12);
            repeat (n) begin
                send_random(make_cmd(OP_READ, col0 + $urandom_range(0, 7),
                                     row0 + $urandom_range(0, 7),
                                     1'($urandom_range(0, 1))));
            end
            n = $urandom_range(0, 4);
            repeat (n) begin
                send_random(make_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                                     $urandom_range(0, 63), 1'($urandom_range(0, 1))));
            end
            if ($urandom_range(0, 9) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lge_pkg.sv
sv/lge_col_mem.sv
sv/lge_col_rule.sv
sv/life_grid_generation_engine_top.sv
sv/lge_checker.sv
sim/lge_checker.sv
sim/testbench.sv
